@@ hdl/nested_span_stack_tracker_defines.svh @@
// assertion helpers shared by the span tracker modules
`ifndef NESTED_SPAN_STACK_TRACKER_DEFINES_SVH
`define NESTED_SPAN_STACK_TRACKER_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define NSST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define NSST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/nsst_pkg.sv @@
`default_nettype none

package nsst_pkg;

   localparam int STACK_DEPTH_DEF = 128;
   localparam int SPAN_SLOTS_DEF  = 256;

   localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] XS_MULT     = 64'h2545_F491_4F6C_DD1D;
   localparam logic [15:0] CNT_MAX     = 16'hFFFF;

   // request kinds
   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_END   = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OPENED       = 3'd0;
   localparam logic [2:0] ST_OPENED_UNREC = 3'd1;
   localparam logic [2:0] ST_OVERFLOW     = 3'd2;
   localparam logic [2:0] ST_CLOSED       = 3'd3;
   localparam logic [2:0] ST_CLOSED_UNREC = 3'd4;
   localparam logic [2:0] ST_IGNORED      = 3'd5;
   localparam logic [2:0] ST_INACTIVE     = 3'd6;

   // register indexes
   localparam logic [0:0] CSR_RNG_SEED      = 1'b0;
   localparam logic [0:0] CSR_REMOTE_PARENT = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] now_ns;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  slot;
      logic [63:0] span_id;
      logic [63:0] parent_span;
      logic [63:0] elapsed_ns;
      logic [15:0] dropped_count;
      logic [7:0]  stack_depth;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ hdl/nsst_ram.sv @@
`default_nettype none

module nsst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/nsst_idgen.sv @@
`default_nettype none

`include "nested_span_stack_tracker_defines.svh"

module nsst_idgen
   import nsst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] seed,
   output logic             done,
   output logic [63:0]      id
);

   typedef enum logic [2:0] {G_IDLE, G_LL, G_HL, G_LH, G_SUM} gen_state_type;

   gen_state_type state_ff, state_in;
   logic [63:0]   rng_ff, rng_in;
   logic [63:0]   p0_ff, p0_in;
   logic [31:0]   p1_ff, p1_in;
   logic [31:0]   p2_ff, p2_in;
   logic [63:0]   id_ff, id_in;
   logic          done_ff, done_in;

   logic [63:0] x_base, xs1, xs2, xs3;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   // a zero state picks up the seed, a zero seed the golden constant
   assign x_base = (rng_ff != 64'd0) ? rng_ff : ((seed != 64'd0) ? seed : GOLDEN_SEED);
   assign xs1    = x_base ^ (x_base >> 12);
   assign xs2    = xs1 ^ (xs1 << 25);
   assign xs3    = xs2 ^ (xs2 >> 27);

   // low 64 bits of state * multiplier from three 32x32 partial products
   always_comb begin
      case (state_ff)
         G_HL: begin
            mul_a = rng_ff[63:32];
            mul_b = XS_MULT[31:0];
         end
         G_LH: begin
            mul_a = rng_ff[31:0];
            mul_b = XS_MULT[63:32];
         end
         default: begin
            mul_a = rng_ff[31:0];
            mul_b = XS_MULT[31:0];
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      rng_in   = rng_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      id_in    = id_ff;
      done_in  = 1'b0;
      case (state_ff)
         G_IDLE: begin
            if (start) begin
               rng_in   = xs3;
               state_in = G_LL;
            end
         end
         G_LL: begin
            p0_in    = mul_p;
            state_in = G_HL;
         end
         G_HL: begin
            p1_in    = mul_p[31:0];
            state_in = G_LH;
         end
         G_LH: begin
            p2_in    = mul_p[31:0];
            state_in = G_SUM;
         end
         G_SUM: begin
            id_in    = p0_ff + {p1_ff + p2_ff, 32'h0};
            done_in  = 1'b1;
            state_in = G_IDLE;
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         rng_ff   <= 64'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rng_ff   <= rng_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      id_ff <= id_in;
   end

   assign done = done_ff;
   assign id   = id_ff;

   `NSST_ASSERT_NEXT(a_done_single, done_ff, !done_ff, "id done held for more than one cycle")
   `NSST_ASSERT_NOW(a_start_when_idle, start, state_ff == G_IDLE, "id requested while busy")
   `NSST_ASSERT_NEXT(a_state_nonzero, state_ff == G_LL, rng_ff != 64'd0, "generator state zero")

endmodule

`default_nettype wire

@@ hdl/nested_span_stack_tracker.sv @@
// Span stack tracker for one request at a time.
// Request channel (req_valid / req_stall / req_data): one event each, begin span,
// end span or start request, with its timestamp in ns.
// Result channel (rsp_valid / rsp_stall / rsp_data): exactly one result per event,
// in order, held in an output register until taken.
// Register port (csr_valid / csr_ready / csr_index / csr_wdata): index 0 is the
// generator seed, index 1 the remote parent id; always ready, write only when idle.
// Flow: one event at a time. Each event reads the stack memory at the top entry,
// then does the update, with a write of the new entry on a push. An event that
// opens a recorded span then waits for the id generator, which forms the 64-bit
// product over three passes of one 32x32 multiplier.
// Reset clears all counters, leaves the block inactive and sets the seed to its
// default; stack memory contents are not cleared and need no clearing pass.
// A stalled result stays in the output register; the next event is still taken
// and worked on, and waits in the last step until the register is free.
`default_nettype none

`include "nested_span_stack_tracker_defines.svh"

module nested_span_stack_tracker
   import nsst_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int SPAN_SLOTS  = SPAN_SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);

   localparam int SLOT_W  = $clog2(SPAN_SLOTS + 1);
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam logic [SLOT_W-1:0]  SLOT_LIMIT = SLOT_W'(SPAN_SLOTS);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX  = DEPTH_W'(STACK_DEPTH);

   // stack entry: table slot (or the unrecorded marker), id of the nearest
   // recorded span below it (or the remote parent), and its start time
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [63:0]       below_id;
      logic [63:0]       start_ns;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_GEN, S_OUT} state_type;

   state_type          state_ff, state_in;
   req_item_type       req_ff, req_in;
   rsp_item_type       res_ff, res_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               active_ff, active_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [SLOT_W-1:0]  used_ff, used_in;
   logic [15:0]        ovf_ff, ovf_in;
   logic [15:0]        drop_ff, drop_in;
   logic [63:0]        top_parent_ff, top_parent_in;
   logic [63:0]        rng_seed_ff;
   logic [63:0]        remote_parent_ff;

   logic               push;
   logic [DEPTH_W-1:0] eff_depth;
   logic [SLOT_W-1:0]  eff_used;
   logic [63:0]        eff_parent;
   logic [15:0]        eff_drop;
   logic [DEPTH_W-1:0] top_idx;
   logic               out_free;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_entry;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          top_entry;

   logic               gen_start;
   logic               gen_done;
   logic [63:0]        gen_id;

   nsst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (top_idx[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   nsst_idgen u_idgen (
      .clock (clock),
      .reset (reset),
      .start (gen_start),
      .seed  (rng_seed_ff),
      .done  (gen_done),
      .id    (gen_id)
   );

   assign top_idx   = depth_ff - DEPTH_W'(1);
   assign top_entry = rd_data;
   assign rd_en     = (state_ff == S_IDLE) && req_valid;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      active_in     = active_ff;
      depth_in      = depth_ff;
      used_in       = used_ff;
      ovf_in        = ovf_ff;
      drop_in       = drop_ff;
      top_parent_in = top_parent_ff;
      push          = 1'b0;
      eff_depth     = depth_ff;
      eff_used      = used_ff;
      eff_parent    = top_parent_ff;
      eff_drop      = drop_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_entry      = '0;
      gen_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in        = '0;
            res_in.status = ST_IGNORED;
            case (req_ff.req_type)
               REQ_START: begin
                  active_in  = 1'b1;
                  ovf_in     = '0;
                  eff_depth  = '0;
                  eff_used   = '0;
                  eff_parent = remote_parent_ff;
                  eff_drop   = '0;
                  push       = 1'b1;
               end
               REQ_BEGIN: begin
                  if (!active_ff) begin
                     res_in.status = ST_INACTIVE;
                  end else if (depth_ff >= DEPTH_MAX) begin
                     if (ovf_ff != CNT_MAX) begin
                        ovf_in = ovf_ff + 16'd1;
                     end
                     res_in.status = ST_OVERFLOW;
                  end else begin
                     push = 1'b1;
                  end
               end
               REQ_END: begin
                  if (!active_ff) begin
                     res_in.status = ST_INACTIVE;
                  end else if (ovf_ff != 16'd0) begin
                     ovf_in = ovf_ff - 16'd1;
                  end else if (depth_ff > DEPTH_W'(1)) begin
                     // root stays; the popped entry restores the parent below it
                     depth_in      = top_idx;
                     top_parent_in = top_entry.below_id;
                     if (top_entry.slot < SLOT_LIMIT) begin
                        res_in.status     = ST_CLOSED;
                        res_in.slot       = 8'(top_entry.slot);
                        res_in.elapsed_ns = req_ff.now_ns - top_entry.start_ns;
                     end else begin
                        res_in.status = ST_CLOSED_UNREC;
                     end
                  end
               end
               default: begin
               end
            endcase
            used_in = eff_used;
            drop_in = eff_drop;
            if (push) begin
               wr_en             = 1'b1;
               wr_addr           = eff_depth[ADDR_W-1:0];
               wr_entry.below_id = eff_parent;
               wr_entry.start_ns = req_ff.now_ns;
               depth_in          = eff_depth + DEPTH_W'(1);
               top_parent_in     = eff_parent;
               if (eff_used < SLOT_LIMIT) begin
                  wr_entry.slot      = eff_used;
                  used_in            = eff_used + SLOT_W'(1);
                  res_in.status      = ST_OPENED;
                  res_in.slot        = 8'(eff_used);
                  res_in.parent_span = eff_parent;
                  gen_start          = 1'b1;
                  state_in           = S_GEN;
               end else begin
                  wr_entry.slot = SLOT_LIMIT;
                  if (eff_drop != CNT_MAX) begin
                     drop_in = eff_drop + 16'd1;
                  end
                  res_in.status = ST_OPENED_UNREC;
                  state_in      = S_OUT;
               end
            end else begin
               state_in = S_OUT;
            end
            res_in.dropped_count = drop_in;
            res_in.stack_depth   = 8'(depth_in);
         end
         S_GEN: begin
            if (gen_done) begin
               res_in.span_id = gen_id;
               top_parent_in  = gen_id;
               state_in       = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= 1'b0;
         depth_ff      <= '0;
         used_ff       <= '0;
         ovf_ff        <= '0;
         drop_ff       <= '0;
         top_parent_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         active_ff     <= active_in;
         depth_ff      <= depth_in;
         used_ff       <= used_in;
         ovf_ff        <= ovf_in;
         drop_ff       <= drop_in;
         top_parent_ff <= top_parent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_seed_ff      <= GOLDEN_SEED;
         remote_parent_ff <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RNG_SEED: begin
               rng_seed_ff <= csr_wdata;
            end
            CSR_REMOTE_PARENT: begin
               remote_parent_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NSST_ASSERT_NOW(a_depth_bound, 1'b1, depth_ff <= DEPTH_MAX, "stack depth beyond capacity")
   `NSST_ASSERT_NOW(a_used_bound, 1'b1, used_ff <= SLOT_LIMIT, "slot count beyond table size")
   `NSST_ASSERT_NOW(a_active_root, active_ff, depth_ff != '0, "active without a root span")
   `NSST_ASSERT_NOW(a_idle_empty, !active_ff, (depth_ff == '0) && (used_ff == '0), "state while inactive")
   `NSST_ASSERT_NEXT(a_gen_wait, gen_start, state_ff == S_GEN, "id requested outside an open")

endmodule

`default_nettype wire
